// ===== hw/rtl/hidrp_pkg.sv =====
`timescale 1ns / 1ps
package hidrp_pkg;
    localparam int SaveStackLevels = 8;
    localparam int UsageListDepth  = 16;
    localparam int MaxNesting      = 15;
    localparam int LvlW = $clog2(SaveStackLevels + 1);
    localparam int SIdxW = (SaveStackLevels > 1) ? $clog2(SaveStackLevels) : 1;
    localparam int UCntW = $clog2(UsageListDepth + 1);
    localparam int UIdxW = (UsageListDepth > 1) ? $clog2(UsageListDepth) : 1;
    localparam int DepW = $clog2(MaxNesting + 1);

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    localparam logic [3:0] MAIN_INPUT     = 4'h8;
    localparam logic [3:0] MAIN_OUTPUT    = 4'h9;
    localparam logic [3:0] MAIN_COLL      = 4'hA;
    localparam logic [3:0] MAIN_FEATURE   = 4'hB;
    localparam logic [3:0] MAIN_END_COLL  = 4'hC;

    localparam logic [3:0] GL_PAGE = 4'h0, GL_LMIN = 4'h1, GL_LMAX = 4'h2,
        GL_PMIN = 4'h3, GL_PMAX = 4'h4, GL_EXP = 4'h5, GL_UNIT = 4'h6,
        GL_SIZE = 4'h7, GL_RID = 4'h8, GL_COUNT = 4'h9, GL_PUSH = 4'hA,
        GL_POP = 4'hB;
    localparam logic [3:0] LC_USAGE = 4'h0, LC_UMIN = 4'h1, LC_UMAX = 4'h2;

    localparam logic [2:0] EV_INPUT = 3'd0, EV_OUTPUT = 3'd1, EV_FEATURE = 3'd2,
        EV_OPEN = 3'd3, EV_CLOSE = 3'd4;

    localparam logic [3:0] AT_FLAGS = 4'd0, AT_RID = 4'd1, AT_PAGE = 4'd2,
        AT_SIZE = 4'd3, AT_COUNT = 4'd4, AT_LMIN = 4'd5, AT_LMAX = 4'd6,
        AT_PMIN = 4'd7, AT_PMAX = 4'd8, AT_UNIT = 4'd9, AT_EXP = 4'd10,
        AT_USAGE = 4'd11, AT_TYPE = 4'd12, AT_CLOSE = 4'd13;

    typedef struct packed {
        logic [15:0] page;
        logic [7:0]  rid;
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [31:0] pmin;
        logic [31:0] pmax;
        logic [31:0] unit;
        logic [7:0]  uexp;
    } t_globals;
endpackage

// ===== hw/rtl/hidrp_if.sv =====
`timescale 1ns / 1ps
interface hidrp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_type;
    logic [3:0]  item_tag;
    logic [2:0]  item_size;
    logic [31:0] item_data;
    modport source (output valid, item_type, item_tag, item_size, item_data, input ready);
    modport sink (input valid, item_type, item_tag, item_size, item_data, output ready);
endinterface

interface hidrp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [3:0]         attribute;
    logic signed [32:0] value;
    logic [3:0]         depth;
    logic               usage_truncated;
    logic               last;
    modport source (output valid, event_res, attribute, value, depth, usage_truncated, last,
        input ready);
    modport sink (input valid, event_res, attribute, value, depth, usage_truncated, last,
        output ready);
endinterface

// ===== hw/rtl/hid_report_descriptor_parser_top.sv =====
`timescale 1ns / 1ps
// channel | dir | payload
// i_item  | in  | item_type, item_tag, item_size, item_data
// o_res   | out | event_res, attribute, value, depth, usage_truncated, last
// Global and local items are applied in S_EXEC after the accept; a pop also passes
// through S_POP for the registered stack read. Input/output/feature emit one result
// per cycle while o_res does not stall, with N usages up to UsageListDepth;
// collections go through S_COLL. The usage list memory has one registered
// read port, read one entry ahead. Each result sits in an output register with its
// depth; a stall on o_res holds the sequencer. Reset is synchronous; stack and list
// contents are not cleared.
module hid_report_descriptor_parser_top import hidrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hidrp_in_if.sink    i_item,
    hidrp_out_if.source o_res
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_POP, S_EMIT, S_COLL} t_state;

    t_state             r_state;
    logic [1:0]         r_type;
    logic [3:0]         r_tag;
    logic [31:0]        r_data, r_sdata;
    t_globals           r_g;
    logic [LvlW-1:0]    r_lvl;
    logic [UCntW-1:0]   r_ucnt;
    logic [31:0]        r_umin, r_umax;
    logic               r_uvalid, r_uovf;
    logic [DepW-1:0]    r_depth;
    logic [4:0]         r_step;
    logic [UCntW-1:0]   r_ui;
    logic [UCntW-1:0]   r_un;
    logic [32:0]        r_ucur;
    logic               r_tr;
    logic [2:0]         r_ev;
    logic               r_ov;
    logic [2:0]         r_oev;
    logic [3:0]         r_oat;
    logic [32:0]        r_oval;
    logic [DepW-1:0]    r_odep;
    logic               r_otr, r_olast;

    t_globals    r_stack [SaveStackLevels];
    t_globals    r_stk_rd;
    logic [31:0] r_ulist [UsageListDepth];
    logic [31:0] r_ul_rd;

    logic [31:0] w_data, w_sdata;
    logic        w_out_free;
    logic        w_load;

    always_comb begin
        logic [2:0] b;
        b = (i_item.item_size > 3'd4) ? 3'd4 : i_item.item_size;
        unique case (b)
            3'd0: begin w_data = '0; w_sdata = '0; end
            3'd1: begin
                w_data = {24'd0, i_item.item_data[7:0]};
                w_sdata = {{24{i_item.item_data[7]}}, i_item.item_data[7:0]};
            end
            3'd2: begin
                w_data = {16'd0, i_item.item_data[15:0]};
                w_sdata = {{16{i_item.item_data[15]}}, i_item.item_data[15:0]};
            end
            3'd3: begin
                w_data = {8'd0, i_item.item_data[23:0]};
                w_sdata = {{8{i_item.item_data[23]}}, i_item.item_data[23:0]};
            end
            default: begin w_data = i_item.item_data; w_sdata = i_item.item_data; end
        endcase
    end

    assign w_out_free = !r_ov || o_res.ready;
    assign w_load = w_out_free && (r_state == S_COLL || r_state == S_EMIT);
    assign i_item.ready = (r_state == S_IDLE);

    assign o_res.valid = r_ov;
    assign o_res.event_res = r_oev;
    assign o_res.attribute = r_oat;
    assign o_res.value = r_oval;
    assign o_res.depth = 4'(r_odep);
    assign o_res.usage_truncated = r_otr;
    assign o_res.last = r_olast;

    // stack memory
    logic w_push, w_popr;
    assign w_push = (r_state == S_EXEC) && (r_type == TYPE_GLOBAL) && (r_tag == GL_PUSH)
        && (r_lvl < LvlW'(SaveStackLevels));
    assign w_popr = (r_state == S_EXEC) && (r_type == TYPE_GLOBAL) && (r_tag == GL_POP)
        && (r_lvl != '0);
    always_ff @(posedge i_clk) begin
        if (w_push) r_stack[r_lvl[SIdxW-1:0]] <= r_g;
        r_stk_rd <= r_stack[SIdxW'(r_lvl - LvlW'(1))];
    end

    // usage list memory: write on local usage, read address from sequencer
    logic w_uwr;
    logic [UIdxW-1:0] w_uraddr;
    assign w_uwr = (r_state == S_EXEC) && (r_type == TYPE_LOCAL) && (r_tag == LC_USAGE)
        && (r_ucnt < UCntW'(UsageListDepth));
    always_comb begin
        if (r_state == S_EXEC)
            w_uraddr = (r_type == TYPE_MAIN && r_tag == MAIN_COLL)
                ? UIdxW'(r_ucnt - UCntW'(1)) : '0;
        else if (r_state == S_COLL)
            w_uraddr = UIdxW'(r_un - UCntW'(1));
        else if (w_out_free && r_step > 5'd10)
            w_uraddr = UIdxW'(r_ui + UCntW'(1));
        else
            w_uraddr = UIdxW'(r_ui);
    end
    always_ff @(posedge i_clk) begin
        if (w_uwr) r_ulist[r_ucnt[UIdxW-1:0]] <= r_data;
        r_ul_rd <= r_ulist[w_uraddr];
    end

    // range length, computed on entry into a field emit
    logic [32:0] w_rlen;
    assign w_rlen = {1'b0, r_umax} - {1'b0, r_umin} + 33'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_g <= '0;
            r_lvl <= '0;
            r_ucnt <= '0;
            r_umin <= '0;
            r_umax <= '0;
            r_uvalid <= 1'b0;
            r_uovf <= 1'b0;
            r_depth <= '0;
            r_ov <= 1'b0;
            r_step <= '0;
            r_ui <= '0;
        end else begin
            if (w_load) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_type <= i_item.item_type;
                        r_tag <= i_item.item_tag;
                        r_data <= w_data;
                        r_sdata <= w_sdata;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_type)
                        TYPE_GLOBAL: begin
                            r_state <= w_popr ? S_POP : S_IDLE;
                            unique case (r_tag)
                                GL_PAGE:  r_g.page <= r_data[15:0];
                                GL_LMIN:  r_g.lmin <= r_sdata;
                                GL_LMAX:  r_g.lmax <= r_sdata;
                                GL_PMIN:  r_g.pmin <= r_sdata;
                                GL_PMAX:  r_g.pmax <= r_sdata;
                                GL_EXP:   r_g.uexp <= r_sdata[7:0];
                                GL_UNIT:  r_g.unit <= r_data;
                                GL_SIZE:  r_g.size <= r_data;
                                GL_RID:   r_g.rid <= r_data[7:0];
                                GL_COUNT: r_g.count <= r_data;
                                GL_PUSH: if (w_push) r_lvl <= r_lvl + LvlW'(1);
                                GL_POP: if (w_popr) r_lvl <= r_lvl - LvlW'(1);
                                default: ;
                            endcase
                        end
                        TYPE_LOCAL: begin
                            r_state <= S_IDLE;
                            unique case (r_tag)
                                LC_USAGE: begin
                                    if (w_uwr) r_ucnt <= r_ucnt + UCntW'(1);
                                    else r_uovf <= 1'b1;
                                end
                                LC_UMIN: begin r_uvalid <= 1'b1; r_umin <= r_data; end
                                LC_UMAX: begin r_uvalid <= 1'b1; r_umax <= r_data; end
                                default: ;
                            endcase
                        end
                        TYPE_MAIN: begin
                            r_ucnt <= '0;
                            r_umin <= '0;
                            r_umax <= '0;
                            r_uvalid <= 1'b0;
                            r_uovf <= 1'b0;
                            r_step <= '0;
                            r_ui <= '0;
                            priority case (r_tag)
                                MAIN_INPUT, MAIN_OUTPUT, MAIN_FEATURE: begin
                                    r_ev <= (r_tag == MAIN_INPUT) ? EV_INPUT :
                                        (r_tag == MAIN_OUTPUT) ? EV_OUTPUT : EV_FEATURE;
                                    r_state <= S_EMIT;
                                    // top bit marks range mode
                                    r_ucur <= {r_uvalid, r_umin};
                                    if (r_uvalid) begin
                                        if (r_umin <= r_umax) begin
                                            r_tr <= w_rlen > 33'(UsageListDepth);
                                            r_un <= (w_rlen > 33'(UsageListDepth))
                                                ? UCntW'(UsageListDepth) : UCntW'(w_rlen);
                                        end else begin
                                            r_tr <= 1'b0;
                                            r_un <= '0;
                                        end
                                    end else begin
                                        r_tr <= r_uovf;
                                        r_un <= r_ucnt;
                                    end
                                end
                                MAIN_COLL: begin
                                    r_ev <= EV_OPEN;
                                    r_tr <= r_uovf;
                                    r_un <= r_ucnt;
                                    if (r_depth < DepW'(MaxNesting))
                                        r_depth <= r_depth + DepW'(1);
                                    r_state <= S_COLL;
                                end
                                MAIN_END_COLL: begin
                                    r_ev <= EV_CLOSE;
                                    if (r_depth != '0) r_depth <= r_depth - DepW'(1);
                                    r_state <= S_COLL;
                                end
                                default: r_state <= S_IDLE;
                            endcase
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_POP: begin
                    r_g <= r_stk_rd;
                    r_state <= S_IDLE;
                end
                S_COLL: begin
                    if (w_out_free) begin
                        r_oev <= r_ev;
                        r_odep <= r_depth;
                        if (r_ev == EV_CLOSE) begin
                            r_oat <= AT_CLOSE;
                            r_oval <= '0;
                            r_otr <= 1'b0;
                            r_olast <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_otr <= r_tr;
                            r_step <= r_step + 5'd1;
                            r_olast <= (r_step == 5'd2);
                            unique case (r_step[1:0])
                                2'd0: begin r_oat <= AT_TYPE; r_oval <= {25'd0, r_data[7:0]}; end
                                2'd1: begin r_oat <= AT_PAGE; r_oval <= {17'd0, r_g.page}; end
                                default: begin
                                    r_oat <= AT_USAGE;
                                    r_oval <= (r_un != '0) ? {1'b0, r_ul_rd} : '0;
                                    r_state <= S_IDLE;
                                end
                            endcase
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_oev <= r_ev;
                        r_odep <= r_depth;
                        r_otr <= r_tr;
                        if (r_step <= 5'd10) begin
                            r_step <= r_step + 5'd1;
                            r_olast <= (r_step == 5'd10 && r_un == '0);
                            if (r_step == 5'd10 && r_un == '0)
                                r_state <= S_IDLE;
                            unique case (r_step[3:0])
                                4'd0: begin r_oat <= AT_FLAGS; r_oval <= {25'd0, r_data[7:0]}; end
                                4'd1: begin r_oat <= AT_RID; r_oval <= {25'd0, r_g.rid}; end
                                4'd2: begin r_oat <= AT_PAGE; r_oval <= {17'd0, r_g.page}; end
                                4'd3: begin r_oat <= AT_SIZE; r_oval <= {1'b0, r_g.size}; end
                                4'd4: begin r_oat <= AT_COUNT; r_oval <= {1'b0, r_g.count}; end
                                4'd5: begin
                                    r_oat <= AT_LMIN; r_oval <= {r_g.lmin[31], r_g.lmin};
                                end
                                4'd6: begin
                                    r_oat <= AT_LMAX; r_oval <= {r_g.lmax[31], r_g.lmax};
                                end
                                4'd7: begin
                                    r_oat <= AT_PMIN; r_oval <= {r_g.pmin[31], r_g.pmin};
                                end
                                4'd8: begin
                                    r_oat <= AT_PMAX; r_oval <= {r_g.pmax[31], r_g.pmax};
                                end
                                4'd9: begin r_oat <= AT_UNIT; r_oval <= {1'b0, r_g.unit}; end
                                default: begin
                                    r_oat <= AT_EXP;
                                    r_oval <= {{25{r_g.uexp[7]}}, r_g.uexp};
                                end
                            endcase
                        end else begin
                            r_oat <= AT_USAGE;
                            r_oval <= r_ucur[32] ? {1'b0, r_ucur[31:0] + 32'(r_ui)}
                                : {1'b0, r_ul_rd};
                            r_ui <= r_ui + UCntW'(1);
                            r_olast <= (r_ui + UCntW'(1) == r_un);
                            if (r_ui + UCntW'(1) == r_un)
                                r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import hidrp_pkg::*;

    typedef struct packed {
        logic [1:0]  itype;
        logic [3:0]  tag;
        logic [2:0]  size;
        logic [31:0] data;
    } t_item;

    typedef struct packed {
        logic [2:0]         ev;
        logic [3:0]         attr;
        logic signed [32:0] value;
        logic [3:0]         depth;
        logic               trunc;
        logic               last;
    } t_res;

    localparam int WatchdogLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    hidrp_in_if  item_if ();
    hidrp_out_if res_if ();

    hid_report_descriptor_parser_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_if.sink),
        .o_res  (res_if.source)
    );

    // predictor state
    t_globals   cur_g;
    t_globals   save_stk[SaveStackLevels];
    int         save_lvl;
    logic [31:0] ulist[UsageListDepth];
    int         ucnt;
    logic [31:0] rng_lo, rng_hi;
    logic       rng_valid, uovf;
    int         nest;

    t_item pending_items[$];
    t_res  expected_res[$];
    int    errors = 0;
    bit    stim_done = 0;
    int    hold_off = 0;

    function automatic logic [32:0] sx32(logic [31:0] v);
        return {v[31], v};
    endfunction

    task automatic push_res(logic [2:0] ev, logic [3:0] attr, logic [32:0] val, logic tr);
        t_res r;
        r.ev = ev; r.attr = attr; r.value = val; r.depth = nest[3:0];
        r.trunc = tr; r.last = 1'b0;
        expected_res.insert(expected_res.size(), r);
    endtask

    task automatic clear_locals();
        ucnt = 0; rng_lo = '0; rng_hi = '0; rng_valid = 0; uovf = 0;
    endtask

    task automatic predict_field(logic [2:0] ev, logic [31:0] d);
        logic tr;
        logic [32:0] n;
        logic [32:0] u;
        int i;
        if (rng_valid) begin
            n = (rng_lo <= rng_hi) ? {1'b0, rng_hi} - {1'b0, rng_lo} + 33'd1 : 33'd0;
            tr = n > UsageListDepth;
        end else begin
            tr = uovf;
        end
        push_res(ev, AT_FLAGS, {25'd0, d[7:0]}, tr);
        push_res(ev, AT_RID, {25'd0, cur_g.rid}, tr);
        push_res(ev, AT_PAGE, {17'd0, cur_g.page}, tr);
        push_res(ev, AT_SIZE, {1'b0, cur_g.size}, tr);
        push_res(ev, AT_COUNT, {1'b0, cur_g.count}, tr);
        push_res(ev, AT_LMIN, sx32(cur_g.lmin), tr);
        push_res(ev, AT_LMAX, sx32(cur_g.lmax), tr);
        push_res(ev, AT_PMIN, sx32(cur_g.pmin), tr);
        push_res(ev, AT_PMAX, sx32(cur_g.pmax), tr);
        push_res(ev, AT_UNIT, {1'b0, cur_g.unit}, tr);
        push_res(ev, AT_EXP, {{25{cur_g.uexp[7]}}, cur_g.uexp}, tr);
        if (rng_valid) begin
            if (rng_lo <= rng_hi) begin
                u = {1'b0, rng_lo};
                for (i = 0; i < UsageListDepth && u <= {1'b0, rng_hi}; i++) begin
                    push_res(ev, AT_USAGE, u, tr);
                    u = u + 1;
                end
            end
        end else begin
            for (i = 0; i < ucnt; i++) push_res(ev, AT_USAGE, {1'b0, ulist[i]}, tr);
        end
    endtask

    task automatic predict_item(t_item it);
        int bytes;
        int res_mark;
        logic [31:0] d, sd, u;
        logic tr;
        bytes = (it.size > 4) ? 4 : it.size;
        d = (bytes == 0) ? 32'd0 : (bytes == 4 ? it.data : it.data & ((32'd1 << (8 * bytes)) - 1));
        case (bytes)
            1: sd = {{24{d[7]}}, d[7:0]};
            2: sd = {{16{d[15]}}, d[15:0]};
            3: sd = {{8{d[23]}}, d[23:0]};
            4: sd = d;
            default: sd = '0;
        endcase
        res_mark = expected_res.size();
        if (it.itype == TYPE_MAIN) begin
            case (it.tag)
                MAIN_INPUT:   predict_field(EV_INPUT, d);
                MAIN_OUTPUT:  predict_field(EV_OUTPUT, d);
                MAIN_FEATURE: predict_field(EV_FEATURE, d);
                MAIN_COLL: begin
                    tr = uovf;
                    u = (ucnt > 0) ? ulist[ucnt - 1] : 32'd0;
                    if (nest < MaxNesting) nest++;
                    push_res(EV_OPEN, AT_TYPE, {25'd0, d[7:0]}, tr);
                    push_res(EV_OPEN, AT_PAGE, {17'd0, cur_g.page}, tr);
                    push_res(EV_OPEN, AT_USAGE, {1'b0, u}, tr);
                end
                MAIN_END_COLL: begin
                    if (nest > 0) nest--;
                    push_res(EV_CLOSE, AT_CLOSE, 33'd0, 1'b0);
                end
                default: ;
            endcase
            clear_locals();
            if (expected_res.size() > res_mark)
                expected_res[expected_res.size() - 1].last = 1'b1;
        end else if (it.itype == TYPE_GLOBAL) begin
            case (it.tag)
                GL_PAGE:  cur_g.page = d[15:0];
                GL_LMIN:  cur_g.lmin = sd;
                GL_LMAX:  cur_g.lmax = sd;
                GL_PMIN:  cur_g.pmin = sd;
                GL_PMAX:  cur_g.pmax = sd;
                GL_EXP:   cur_g.uexp = sd[7:0];
                GL_UNIT:  cur_g.unit = d;
                GL_SIZE:  cur_g.size = d;
                GL_RID:   cur_g.rid = d[7:0];
                GL_COUNT: cur_g.count = d;
                GL_PUSH:  if (save_lvl < SaveStackLevels) save_stk[save_lvl++] = cur_g;
                GL_POP:   if (save_lvl > 0) cur_g = save_stk[--save_lvl];
                default: ;
            endcase
        end else if (it.itype == TYPE_LOCAL) begin
            case (it.tag)
                LC_USAGE: begin
                    if (ucnt < UsageListDepth) ulist[ucnt++] = d;
                    else uovf = 1;
                end
                LC_UMIN: begin rng_valid = 1; rng_lo = d; end
                LC_UMAX: begin rng_valid = 1; rng_hi = d; end
                default: ;
            endcase
        end
    endtask

    function automatic t_item mk(logic [1:0] ty, logic [3:0] tg, logic [2:0] sz, logic [31:0] dt);
        t_item it;
        it.itype = ty; it.tag = tg; it.size = sz; it.data = dt;
        return it;
    endfunction

    task automatic add_item(t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [31:0] rnd_data();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] rnd_size();
        return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    endfunction

    // driver
    int send_gap = 0;
    t_item cur_item;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (item_if.valid && item_if.ready) begin
            // handshake already sampled at the posedge below
        end
    end

    logic in_acc;
    always @(posedge i_clk) in_acc <= i_rst_n && item_if.valid && item_if.ready;

    initial begin
        item_if.valid = 1'b0;
        item_if.item_type = '0;
        item_if.item_tag = '0;
        item_if.item_size = '0;
        item_if.item_data = '0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!item_if.valid || in_acc) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    item_if.valid <= 1'b1;
                    item_if.item_type <= cur_item.itype;
                    item_if.item_tag <= cur_item.tag;
                    item_if.item_size <= cur_item.size;
                    item_if.item_data <= cur_item.data;
                    send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && item_if.valid && item_if.ready)
            predict_item(mk(item_if.item_type, item_if.item_tag, item_if.item_size,
                item_if.item_data));
    end

    // receiver
    int recv_gap = 0;
    initial res_if.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_res.size() == 0) begin
                $display("%0t unexpected result ev=%0d attr=%0d val=%0d", $time,
                    res_if.event_res, res_if.attribute, res_if.value);
                errors++;
            end else begin
                exp_r = expected_res.pop_front();
                if (res_if.event_res !== exp_r.ev || res_if.attribute !== exp_r.attr ||
                    res_if.value !== exp_r.value || res_if.depth !== exp_r.depth ||
                    res_if.usage_truncated !== exp_r.trunc || res_if.last !== exp_r.last) begin
                    $display("%0t mismatch exp ev=%0d at=%0d v=%h d=%0d tr=%0d l=%0d",
                        $time, exp_r.ev, exp_r.attr, exp_r.value, exp_r.depth,
                        exp_r.trunc, exp_r.last);
                    $display("%0t          act ev=%0d at=%0d v=%h d=%0d tr=%0d l=%0d",
                        $time, res_if.event_res, res_if.attribute, res_if.value,
                        res_if.depth, res_if.usage_truncated, res_if.last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_field_seq();
        int n, k;
        n = $urandom_range(0, 6);
        for (k = 0; k < n; k++)
            add_item(mk(TYPE_GLOBAL, 4'($urandom_range(0, 9)), rnd_size(), rnd_data()));
        if ($urandom_range(0, 2) == 0) begin
            add_item(mk(TYPE_LOCAL, LC_UMIN, 3'd2, $urandom_range(0, 40)));
            add_item(mk(TYPE_LOCAL, LC_UMAX, 3'd2, $urandom_range(0, 40)));
        end else begin
            n = $urandom_range(0, 18);
            for (k = 0; k < n; k++)
                add_item(mk(TYPE_LOCAL, LC_USAGE, rnd_size(), rnd_data()));
        end
        case ($urandom_range(0, 4))
            0: add_item(mk(TYPE_MAIN, MAIN_INPUT, rnd_size(), rnd_data()));
            1: add_item(mk(TYPE_MAIN, MAIN_OUTPUT, rnd_size(), rnd_data()));
            2: add_item(mk(TYPE_MAIN, MAIN_FEATURE, rnd_size(), rnd_data()));
            3: add_item(mk(TYPE_MAIN, MAIN_COLL, rnd_size(), rnd_data()));
            default: add_item(mk(TYPE_MAIN, MAIN_END_COLL, 3'd0, rnd_data()));
        endcase
    endtask

    initial begin
        int k, total, drain;
        save_lvl = 0; nest = 0;
        cur_g = '0;
        clear_locals();

        // directed: extremes, sign extension, range corners, stack edges
        add_item(mk(TYPE_MAIN, MAIN_END_COLL, 3'd0, 32'd0)); // close at depth 0
        add_item(mk(TYPE_GLOBAL, GL_POP, 3'd0, 32'd0));      // pop on empty
        add_item(mk(TYPE_GLOBAL, GL_LMIN, 3'd1, 32'h80));
        add_item(mk(TYPE_GLOBAL, GL_LMAX, 3'd2, 32'hFFFF_7FFF));
        add_item(mk(TYPE_GLOBAL, GL_PMIN, 3'd4, 32'h8000_0000));
        add_item(mk(TYPE_GLOBAL, GL_PMAX, 3'd3, 32'hFFFF_FFFF));
        add_item(mk(TYPE_GLOBAL, GL_EXP, 3'd1, 32'hF));
        add_item(mk(TYPE_GLOBAL, GL_PAGE, 3'd4, 32'hFFFF_FFFF));
        add_item(mk(TYPE_GLOBAL, GL_RID, 3'd7, 32'hFFFF_FFFF));
        add_item(mk(2'd3, GL_PAGE, 3'd1, 32'h12));           // reserved class
        add_item(mk(TYPE_LOCAL, LC_UMIN, 3'd4, 32'hFFFF_FFFE));
        add_item(mk(TYPE_MAIN, MAIN_INPUT, 3'd1, 32'hFF));   // range, lone bound
        add_item(mk(TYPE_LOCAL, LC_UMIN, 3'd4, 32'hFFFF_FFF0));
        add_item(mk(TYPE_LOCAL, LC_UMAX, 3'd4, 32'hFFFF_FFFF));
        add_item(mk(TYPE_MAIN, MAIN_FEATURE, 3'd0, 32'hFF)); // range exactly at the cap
        add_item(mk(TYPE_LOCAL, LC_UMIN, 3'd1, 32'd9));
        add_item(mk(TYPE_LOCAL, LC_UMAX, 3'd1, 32'd3));
        add_item(mk(TYPE_MAIN, MAIN_OUTPUT, 3'd2, 32'h1234)); // min > max
        for (k = 0; k < 9; k++) add_item(mk(TYPE_GLOBAL, GL_PUSH, 3'd0, 0));
        add_item(mk(TYPE_MAIN, 4'h3, 3'd1, 32'h5));          // unknown main
        for (k = 0; k < 17; k++)
            add_item(mk(TYPE_LOCAL, LC_USAGE, 3'd2, 32'h100 + k));
        add_item(mk(TYPE_MAIN, MAIN_COLL, 3'd1, 32'h1));     // list overflow
        for (k = 0; k < 9; k++) add_item(mk(TYPE_GLOBAL, GL_POP, 3'd0, 0));

        total = pending_items.size();
        while (total < 360) begin
            k = pending_items.size();
            if ($urandom_range(0, 9) == 0) begin
                // noise: any class, tag, size
                add_item(mk(2'($urandom_range(0, 3)), 4'($urandom),
                    3'($urandom_range(0, 7)), $urandom));
            end else if ($urandom_range(0, 7) == 0) begin
                add_item(mk(TYPE_GLOBAL,
                    $urandom_range(0, 1) ? GL_PUSH : GL_POP, 3'd0, 32'd0));
            end else if ($urandom_range(0, 5) == 0) begin
                for (int j = 0; j < 17; j++)
                    add_item(mk(TYPE_MAIN, MAIN_COLL, 3'd1, $urandom));
            end else begin
                add_field_seq();
            end
            total += pending_items.size() - k;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // long receiver hold-off while items keep coming
        repeat (300) @(posedge i_clk);
        hold_off = 400;

        wait (pending_items.size() == 0 && !item_if.valid);
        stim_done = 1;
        drain = 0;
        while ((expected_res.size() > 0 || drain < 60) && drain < 100000) begin
            @(posedge i_clk);
            if (expected_res.size() == 0) drain++;
        end
        if (errors == 0 && expected_res.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
